@@ hw/rtl/obuhp_pkg.sv @@
// ----------------------------------------------------------------------------
// obuhp_pkg
// Shared widths, codes, masks and payload types of the unit header parser.
// ----------------------------------------------------------------------------
package obuhp_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int MASK_W    = 16;
  localparam int REG_IDX_W = 1;
  localparam int STATUS_W  = 3;
  localparam int TYPE_W    = 4;
  localparam int TID_W     = 3;
  localparam int SID_W     = 2;
  localparam int QID_W     = 2;

  // header and extension byte fields
  localparam logic [BYTE_W-1:0] FORBIDDEN_MASK    = 8'h80;
  localparam logic [BYTE_W-1:0] TYPE_MASK         = 8'h78;
  localparam logic [BYTE_W-1:0] RESERVED_MASK     = 8'h06;
  localparam logic [BYTE_W-1:0] EXT_FLAG_MASK     = 8'h01;
  localparam logic [BYTE_W-1:0] TEMPORAL_MASK     = 8'hE0;
  localparam logic [BYTE_W-1:0] SPATIAL_MASK      = 8'h18;
  localparam logic [BYTE_W-1:0] QUALITY_MASK      = 8'h06;
  localparam logic [BYTE_W-1:0] EXT_RESERVED_MASK = 8'h01;

  // length field plus header byte
  localparam logic [WORD_W-1:0] MIN_UNIT_BYTES = 32'd5;

  localparam logic [WORD_W-1:0] BUFFER_LENGTH_RST   = 32'd0;
  localparam logic [MASK_W-1:0] VALID_TYPE_MASK_RST = 16'h803E;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BUFFER_LENGTH   = 1'b0,
    REG_VALID_TYPE_MASK = 1'b1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TRAILING   = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_FORBIDDEN  = 3'd3,
    ST_BAD_TYPE   = 3'd4,
    ST_RESERVED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              buffer_start;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [TYPE_W-1:0] unit_type;
    logic              ext_present;
    logic [TID_W-1:0]  temporal_id;
    logic [SID_W-1:0]  spatial_id;
    logic [QID_W-1:0]  quality_id;
    logic [WORD_W-1:0] unit_offset;
    logic [WORD_W-1:0] unit_length;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] buffer_length;
    logic [MASK_W-1:0] valid_type_mask;
  } cfg_t;

  function automatic logic [TYPE_W-1:0] type_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = (b & TYPE_MASK) >> 3;
    return t[TYPE_W-1:0];
  endfunction

  function automatic logic [TID_W-1:0] temporal_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = (b & TEMPORAL_MASK) >> 5;
    return t[TID_W-1:0];
  endfunction

  function automatic logic [SID_W-1:0] spatial_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = (b & SPATIAL_MASK) >> 3;
    return t[SID_W-1:0];
  endfunction

  function automatic logic [QID_W-1:0] quality_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = (b & QUALITY_MASK) >> 1;
    return t[QID_W-1:0];
  endfunction

endpackage

@@ hw/rtl/obuhp_in_if.sv @@
// ----------------------------------------------------------------------------
// obuhp_in_if
// Byte stream channel into the parser.
// ----------------------------------------------------------------------------
interface obuhp_in_if;
  logic                          valid;
  logic                          ready;
  logic [obuhp_pkg::BYTE_W-1:0]  byte_value;
  logic                          buffer_start;

  modport source (output valid, output byte_value, output buffer_start, input ready);
  modport sink   (input valid, input byte_value, input buffer_start, output ready);
endinterface

@@ hw/rtl/obuhp_out_if.sv @@
// ----------------------------------------------------------------------------
// obuhp_out_if
// Result channel out of the parser, one item per header or error.
// ----------------------------------------------------------------------------
interface obuhp_out_if;
  logic                            valid;
  logic                            ready;
  logic [obuhp_pkg::STATUS_W-1:0]  status;
  logic [obuhp_pkg::TYPE_W-1:0]    unit_type;
  logic                            ext_present;
  logic [obuhp_pkg::TID_W-1:0]     temporal_id;
  logic [obuhp_pkg::SID_W-1:0]     spatial_id;
  logic [obuhp_pkg::QID_W-1:0]     quality_id;
  logic [obuhp_pkg::WORD_W-1:0]    unit_offset;
  logic [obuhp_pkg::WORD_W-1:0]    unit_length;

  modport source (output valid, output status, output unit_type, output ext_present,
                  output temporal_id, output spatial_id, output quality_id,
                  output unit_offset, output unit_length, input ready);
  modport sink   (input valid, input status, input unit_type, input ext_present,
                  input temporal_id, input spatial_id, input quality_id,
                  input unit_offset, input unit_length, output ready);
endinterface

@@ hw/rtl/obuhp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// obuhp_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface obuhp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [obuhp_pkg::REG_IDX_W-1:0]  index;
  logic [obuhp_pkg::WORD_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/obuhp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// obuhp_cfg_regs
// Buffer length and valid type mask registers with their write decoder.
// ----------------------------------------------------------------------------
module obuhp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [obuhp_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [obuhp_pkg::WORD_W-1:0]    wr_data,
  output obuhp_pkg::cfg_t                 cfg
);

  obuhp_pkg::cfg_t cfg_r;
  obuhp_pkg::cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (obuhp_pkg::reg_idx_t'(wr_index))
        obuhp_pkg::REG_BUFFER_LENGTH:   cfg_nxt.buffer_length = wr_data;
        obuhp_pkg::REG_VALID_TYPE_MASK:
          cfg_nxt.valid_type_mask = wr_data[obuhp_pkg::MASK_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_length   <= obuhp_pkg::BUFFER_LENGTH_RST;
      cfg_r.valid_type_mask <= obuhp_pkg::VALID_TYPE_MASK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/obuhp_in_stage.sv @@
// ----------------------------------------------------------------------------
// obuhp_in_stage
// Input register: holds one byte item until the parse step takes it.
// ----------------------------------------------------------------------------
module obuhp_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  obuhp_pkg::in_item_t   in_item,
  input  logic                  down_ready,
  output logic                  take,
  output obuhp_pkg::in_item_t   item
);

  logic                 valid_r;
  logic                 valid_nxt;
  obuhp_pkg::in_item_t  item_r;
  logic                 accept;

  // take the held item whenever the result side has room
  assign take     = valid_r && down_ready;
  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item = item_r;

endmodule

@@ hw/rtl/obuhp_parse.sv @@
// ----------------------------------------------------------------------------
// obuhp_parse
// Parser state and the per-byte step: length field, header, extension and
// payload skip, with the header checks and the result build.
// ----------------------------------------------------------------------------
module obuhp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  obuhp_pkg::in_item_t  item,
  input  obuhp_pkg::cfg_t      cfg,
  output logic                 res_valid,
  output obuhp_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_LEN0    = 3'd0,
    PH_LEN1    = 3'd1,
    PH_LEN2    = 3'd2,
    PH_LEN3    = 3'd3,
    PH_HDR     = 3'd4,
    PH_EXT     = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  logic [obuhp_pkg::WORD_W-1:0] pos_r, pos_nxt, pos_c;
  phase_t                       phase_r, phase_nxt, phase_c;
  logic [obuhp_pkg::WORD_W-1:0] acc_r, acc_nxt, acc_c;
  logic [obuhp_pkg::WORD_W-1:0] left_r, left_nxt, left_c;
  logic [obuhp_pkg::BYTE_W-1:0] hdr_r, hdr_nxt, hdr_c;
  logic                         stopped_r, stopped_nxt, stopped_c;

  logic [obuhp_pkg::WORD_W-1:0] remaining;
  logic [obuhp_pkg::WORD_W-1:0] left_dec;
  logic [obuhp_pkg::WORD_W-1:0] acc_full;
  logic [obuhp_pkg::BYTE_W-1:0] b;
  logic                         ext_flag;

  assign b = item.byte_value;

  // per-byte step
  always_comb begin
    // a buffer start clears the state before the byte is parsed
    if (item.buffer_start) begin
      pos_c     = '0;
      phase_c   = PH_LEN0;
      acc_c     = '0;
      left_c    = '0;
      hdr_c     = '0;
      stopped_c = 1'b0;
    end else begin
      pos_c     = pos_r;
      phase_c   = phase_r;
      acc_c     = acc_r;
      left_c    = left_r;
      hdr_c     = hdr_r;
      stopped_c = stopped_r;
    end

    pos_nxt     = pos_c + 32'd1;
    phase_nxt   = phase_c;
    acc_nxt     = acc_c;
    left_nxt    = left_c;
    hdr_nxt     = hdr_c;
    stopped_nxt = stopped_c;

    remaining = cfg.buffer_length - pos_c;
    left_dec  = left_c - 32'd1;
    acc_full  = acc_c | {b, 24'd0};
    ext_flag  = (b & obuhp_pkg::EXT_FLAG_MASK) != '0;

    res_valid         = 1'b0;
    res.status        = obuhp_pkg::ST_OK;
    res.unit_type     = '0;
    res.ext_present   = 1'b0;
    res.temporal_id   = '0;
    res.spatial_id    = '0;
    res.quality_id    = '0;
    res.unit_offset   = pos_c;
    res.unit_length   = acc_c;

    if (!stopped_c && (pos_c < cfg.buffer_length)) begin
      unique case (phase_c)
        PH_LEN1: begin
          acc_nxt   = acc_c | {16'd0, b, 8'd0};
          phase_nxt = PH_LEN2;
        end
        PH_LEN2: begin
          acc_nxt   = acc_c | {8'd0, b, 16'd0};
          phase_nxt = PH_LEN3;
        end
        PH_LEN3: begin
          acc_nxt = acc_full;
          // remaining is at least one here, so len > remaining - 1 is len >= remaining
          if ((acc_full == '0) || (acc_full >= remaining)) begin
            res_valid       = 1'b1;
            res.status      = obuhp_pkg::ST_BAD_LENGTH;
            res.unit_offset = pos_c + 32'd1;
            res.unit_length = acc_full;
            stopped_nxt     = 1'b1;
          end else begin
            left_nxt  = acc_full;
            phase_nxt = PH_HDR;
          end
        end
        PH_HDR: begin
          left_nxt          = left_dec;
          res_valid         = 1'b1;
          res.unit_type     = obuhp_pkg::type_of(b);
          res.ext_present   = ext_flag;
          // header checks in priority order
          if ((b & obuhp_pkg::FORBIDDEN_MASK) != '0) begin
            res.status  = obuhp_pkg::ST_FORBIDDEN;
            stopped_nxt = 1'b1;
          end else if (!cfg.valid_type_mask[obuhp_pkg::type_of(b)]) begin
            res.status  = obuhp_pkg::ST_BAD_TYPE;
            stopped_nxt = 1'b1;
          end else if ((b & obuhp_pkg::RESERVED_MASK) != '0) begin
            res.status  = obuhp_pkg::ST_RESERVED;
            stopped_nxt = 1'b1;
          end else if (ext_flag && (left_dec == '0)) begin
            res.status  = obuhp_pkg::ST_BAD_LENGTH;
            stopped_nxt = 1'b1;
          end else if (ext_flag) begin
            // result waits for the extension byte
            res_valid = 1'b0;
            hdr_nxt   = b;
            phase_nxt = PH_EXT;
          end else begin
            phase_nxt = (left_dec != '0) ? PH_PAYLOAD : PH_LEN0;
          end
        end
        PH_EXT: begin
          left_nxt          = left_dec;
          res_valid         = 1'b1;
          res.unit_type     = obuhp_pkg::type_of(hdr_c);
          res.ext_present   = (hdr_c & obuhp_pkg::EXT_FLAG_MASK) != '0;
          res.temporal_id   = obuhp_pkg::temporal_of(b);
          res.spatial_id    = obuhp_pkg::spatial_of(b);
          res.quality_id    = obuhp_pkg::quality_of(b);
          res.unit_offset   = pos_c - 32'd1;
          if ((b & obuhp_pkg::EXT_RESERVED_MASK) != '0) begin
            res.status  = obuhp_pkg::ST_RESERVED;
            stopped_nxt = 1'b1;
          end else begin
            phase_nxt = (left_dec != '0) ? PH_PAYLOAD : PH_LEN0;
          end
        end
        PH_PAYLOAD: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_LEN0;
          end
        end
        default: begin
          // first length byte; too few bytes left means trailing data
          if (remaining < obuhp_pkg::MIN_UNIT_BYTES) begin
            res_valid       = 1'b1;
            res.status      = obuhp_pkg::ST_TRAILING;
            res.unit_length = '0;
            stopped_nxt     = 1'b1;
          end else begin
            acc_nxt   = {24'd0, b};
            phase_nxt = PH_LEN1;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_LEN0;
      acc_r     <= '0;
      left_r    <= '0;
      hdr_r     <= '0;
      stopped_r <= 1'b0;
    end else if (take) begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
      hdr_r     <= hdr_nxt;
      stopped_r <= stopped_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a stopped parser stays silent until the next buffer start
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stopped_r && !item.buffer_start) |-> !res_valid)
    else $error("result produced while stopped");

  // every error result stops the parser
  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_valid && (res.status != obuhp_pkg::ST_OK)) |=> stopped_r)
    else $error("parser not stopped after an error");

  // the extension phase is entered only with a held header that has the flag
  a_ext_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EXT) |-> ((hdr_r & obuhp_pkg::EXT_FLAG_MASK) != '0))
    else $error("extension phase without extension flag");
`endif

endmodule

@@ hw/rtl/obuhp_out_stage.sv @@
// ----------------------------------------------------------------------------
// obuhp_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module obuhp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  obuhp_pkg::result_t  res,
  output logic                down_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output obuhp_pkg::result_t  out_res
);

  logic                valid_r;
  logic                valid_nxt;
  obuhp_pkg::result_t  res_r;

  // room when empty or when the held item leaves this cycle
  assign down_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ hw/rtl/obuhp_top.sv @@
// ----------------------------------------------------------------------------
// obu_stream_header_parser_top
// Streaming parser of length-prefixed units: checks each header byte and
// reports one result per header or per error.
// ----------------------------------------------------------------------------
//   port     direction  item
//   in_ch    sink       one buffer byte plus buffer start flag
//   out_ch   source     status, type, extension ids, offset, length
//   cfg_ch   sink       register index and write data
//
// One byte is taken every cycle unless the result side stalls; byte and result are registered.
// The rate is set by the single parse step between the input register and
// the result register. Reset (rst_n low, synchronous) clears the parser state
// and loads the register defaults. A stalled result holds the next byte in the
// input register; in_ch.ready drops only when both registers are full and out_ch.ready is low.
// ----------------------------------------------------------------------------
module obu_stream_header_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  obuhp_in_if.sink     in_ch,
  obuhp_out_if.source  out_ch,
  obuhp_cfg_if.sink    cfg_ch
);

  obuhp_pkg::cfg_t      cfg;
  obuhp_pkg::in_item_t  in_item;
  obuhp_pkg::in_item_t  item;
  obuhp_pkg::result_t   res;
  obuhp_pkg::result_t   out_res;
  logic                 take;
  logic                 down_ready;
  logic                 res_valid;

  // register port is always ready
  assign cfg_ch.ready = 1'b1;

  obuhp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign in_item.byte_value   = in_ch.byte_value;
  assign in_item.buffer_start = in_ch.buffer_start;

  obuhp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .down_ready (down_ready),
    .take       (take),
    .item       (item)
  );

  obuhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  obuhp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && res_valid),
    .res        (res),
    .down_ready (down_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (out_res)
  );

  // result fields onto the channel
  assign out_ch.status        = out_res.status;
  assign out_ch.unit_type     = out_res.unit_type;
  assign out_ch.ext_present   = out_res.ext_present;
  assign out_ch.temporal_id   = out_res.temporal_id;
  assign out_ch.spatial_id    = out_res.spatial_id;
  assign out_ch.quality_id    = out_res.quality_id;
  assign out_ch.unit_offset   = out_res.unit_offset;
  assign out_ch.unit_length   = out_res.unit_length;

`ifndef NO_ASSERTIONS
  // input back-pressure only comes from a full, stalled result register
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a stalled result");
`endif

endmodule
